@@ design/cbft_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbft_pkg
// Shared types and constants for the chunk box frustum test.
// ----------------------------------------------------------------------------
package cbft_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int COEF_W      = 16;
  localparam int Q_FRAC_BITS = 14;
  localparam int PLANE_W     = 4 * COEF_W;
  localparam int CFG_IDX_W   = 3;

  // register index of each plane on the config channel
  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_LEFT   = 3'd0,
    IDX_RIGHT  = 3'd1,
    IDX_BOTTOM = 3'd2,
    IDX_TOP    = 3'd3,
    IDX_NEAR   = 3'd4,
    IDX_FAR    = 3'd5
  } cfg_idx_t;

  // a in the low 16 bits, d in the high 16 bits
  typedef struct packed {
    logic signed [COEF_W-1:0] d;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] a;
  } plane_t;

  // pipeline controls handed to each plane lane
  typedef struct packed {
    logic load;
  } lane_ctrl_t;

endpackage : cbft_pkg
`default_nettype wire

@@ design/cbft_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbft_if
// Valid/ready channels of the chunk box frustum test: chunk requests,
// results and plane register writes.
// ----------------------------------------------------------------------------
interface cbft_chunk_if #(
  parameter int IDX_BITS = 11
);
  logic                       valid;
  logic                       ready;
  logic signed [IDX_BITS-1:0] chunk_x;
  logic signed [IDX_BITS-1:0] chunk_z;

  modport source (output valid, output chunk_x, output chunk_z, input ready);
  modport sink   (input valid, input chunk_x, input chunk_z, output ready);
endinterface : cbft_chunk_if

interface cbft_result_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, output visible, input ready);
  modport sink   (input valid, input visible, output ready);
endinterface : cbft_result_if

interface cbft_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : cbft_cfg_if
`default_nettype wire

@@ design/cbft_plane_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbft_plane_lane
// One frustum plane: registers the coefficient products for the box origin
// and the corner bias, then flags the box as fully behind the plane when the
// farthest corner's scaled distance is negative.
// ----------------------------------------------------------------------------
module cbft_plane_lane #(
  parameter int XW            = 16,
  parameter int AW            = 40,
  parameter int CHUNK_SPAN    = 31,
  parameter int COLUMN_HEIGHT = 40
) (
  input  wire                       clk,
  input  wire cbft_pkg::lane_ctrl_t ctrl,
  input  wire cbft_pkg::plane_t     plane,
  input  wire logic signed [XW-1:0] x0,
  input  wire logic signed [XW-1:0] z0,
  output logic                      behind
);
  import cbft_pkg::*;

  localparam int PW = COEF_W + XW;
  localparam logic signed [AW-1:0] SPAN_A   = AW'(CHUNK_SPAN);
  localparam logic signed [AW-1:0] HEIGHT_A = AW'(COLUMN_HEIGHT);

  logic signed [PW-1:0] ax_next, cz_next;
  logic signed [PW-1:0] ax, cz;
  logic signed [AW-1:0] bias_next, bias;
  logic signed [AW-1:0] a_pos, b_pos, c_pos;
  logic signed [AW-1:0] dist_max;

  assign ax_next = plane.a * x0;
  assign cz_next = plane.c * z0;

  // farthest corner: take the far edge on each axis with a positive coefficient
  assign a_pos = plane.a[COEF_W-1] ? '0 : AW'(plane.a);
  assign b_pos = plane.b[COEF_W-1] ? '0 : AW'(plane.b);
  assign c_pos = plane.c[COEF_W-1] ? '0 : AW'(plane.c);
  assign bias_next = a_pos * SPAN_A + b_pos * HEIGHT_A + c_pos * SPAN_A
                   + (AW'(plane.d) <<< Q_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ax   <= ax_next;
      cz   <= cz_next;
      bias <= bias_next;
    end
  end

  assign dist_max = AW'(ax) + AW'(cz) + bias;
  assign behind   = dist_max[AW-1];

endmodule : cbft_plane_lane
`default_nettype wire

@@ design/chunk_box_frustum_test_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_box_frustum_test_top
// Frustum culling of one chunk's bounding box.
//
// chunk_in carries a chunk grid index pair; result returns one visible bit
// per request, in order. The box spans CHUNK_SPAN units in x and z from the
// chunk origin and 0..COLUMN_HEIGHT in y; it is culled when all corners are
// strictly behind one of the six planes.
// cfg writes the plane registers (index 0..5: left, right, bottom, top,
// near, far); other indexes are dropped. cfg is always ready and must only
// be written while no request is in flight.
// Pipeline: input register, origin multiply, plane products, result
// register. One request is taken every cycle unless the receiver stalls
// with every stage full. When the receiver stalls, the result holds
// and the pipeline fills its empty stages before chunk_in.ready drops.
// Reset clears all planes to zero (every chunk visible) and empties the
// pipeline.
// ----------------------------------------------------------------------------
module chunk_box_frustum_test_top #(
  parameter int CHUNK_SPAN       = 31,
  parameter int COLUMN_HEIGHT    = 40,
  parameter int CHUNK_INDEX_BITS = 11
) (
  input  wire    clk,
  input  wire    rst,
  cbft_chunk_if.sink chunk_in,
  cbft_result_if.source result,
  cbft_cfg_if.sink cfg
);
  import cbft_pkg::*;

  localparam int IB   = CHUNK_INDEX_BITS;
  localparam int SW   = $clog2(CHUNK_SPAN + 1);
  localparam int HW   = $clog2(COLUMN_HEIGHT + 1);
  localparam int XW   = IB + SW + 1;
  localparam int AW0  = COEF_W + XW;
  localparam int AW1  = (AW0 > COEF_W + HW) ? AW0 : COEF_W + HW;
  localparam int AW2  = (AW1 > COEF_W + Q_FRAC_BITS) ? AW1 : COEF_W + Q_FRAC_BITS;
  localparam int AW   = AW2 + 3;
  localparam logic signed [XW-1:0] SPAN_X = XW'(CHUNK_SPAN);

  plane_t planes [PLANE_COUNT];

  logic                 v_a, v_b, v_c, v_d;
  logic                 en_a, en_b, en_c, en_d;
  logic signed [IB-1:0] cx_a, cz_a;
  logic signed [XW-1:0] x0_b, z0_b;
  logic [PLANE_COUNT-1:0] behind;
  logic                 visible;
  lane_ctrl_t           lane_ctrl;

  assign en_d = !v_d || result.ready;
  assign en_c = !v_c || en_d;
  assign en_b = !v_b || en_c;
  assign en_a = !v_a || en_b;

  assign chunk_in.ready = en_a;
  assign cfg.ready      = 1'b1;
  assign result.valid   = v_d;
  assign result.visible = visible;
  assign lane_ctrl.load = en_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      for (int i = 0; i < PLANE_COUNT; i++) begin
        planes[i] <= '0;
      end
    end else begin
      if (en_a) v_a <= chunk_in.valid;
      if (en_b) v_b <= v_a;
      if (en_c) v_c <= v_b;
      if (en_d) v_d <= v_c;
      if (cfg.valid && cfg.index < CFG_IDX_W'(PLANE_COUNT)) begin
        planes[cfg.index] <= plane_t'(cfg.data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      cx_a <= chunk_in.chunk_x;
      cz_a <= chunk_in.chunk_z;
    end
    if (en_b) begin
      x0_b <= XW'(cx_a) * SPAN_X;
      z0_b <= XW'(cz_a) * SPAN_X;
    end
    if (en_d) begin
      visible <= ~|behind;
    end
  end

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
    cbft_plane_lane #(
      .XW            (XW),
      .AW            (AW),
      .CHUNK_SPAN    (CHUNK_SPAN),
      .COLUMN_HEIGHT (COLUMN_HEIGHT)
    ) u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .plane  (planes[p]),
      .x0     (x0_b),
      .z0     (z0_b),
      .behind (behind[p])
    );
  end

endmodule : chunk_box_frustum_test_top
`default_nettype wire
